>>> design/bnd_pkg.sv
// ----------------------------------------------------------------------------
// bnd_pkg
// Shared types and constants for the gray8-to-gray4 threshold dither packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bnd_pkg;

  // Default mask edge length (mask is MASK_EDGE x MASK_EDGE entries).
  localparam int unsigned MASK_EDGE_DEF  = 64;
  // Largest tile width honored; wider settings clamp to this.
  localparam int unsigned MAX_TILE_WIDTH = 4096;

  localparam int unsigned TW_W   = 13;   // tile_width register
  localparam int unsigned ORG_W  = 16;   // origin registers
  localparam int unsigned COL_W  = 12;   // column counter
  localparam int unsigned CFG_AW = 4;    // byte address of three 32-bit registers
  localparam int unsigned CFG_DW = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TILE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_COLUMN = 2'd1;
  localparam logic [1:0] REG_ORIGIN_ROW    = 2'd2;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // gray / 17 as (gray * 241) >> 12, exact for 8-bit gray.
  localparam int unsigned GRAY_STEP        = 17;
  localparam int unsigned GRAY_RECIP       = 241;
  localparam int unsigned GRAY_RECIP_SHIFT = 12;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel_gray;
    logic [11:0] mask_address;
    logic [7:0] mask_threshold;
    logic       tile_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_last;
  } out_item_t;

  // Pixel state carried from the address stage to the pack stage.
  typedef struct packed {
    logic       odd;
    logic       last;
    logic [3:0] base;
    logic [4:0] rem;
  } pix_t;

endpackage

`default_nettype wire

>>> design/bnd_ram.sv
// ----------------------------------------------------------------------------
// bnd_ram
// Generic single-address synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bnd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/bnd_cfg.sv
// ----------------------------------------------------------------------------
// bnd_cfg
// APB-style register file; folds each origin onto the mask phase when written.
// ----------------------------------------------------------------------------
`default_nettype none

module bnd_cfg #(
  parameter int unsigned MASK_EDGE = bnd_pkg::MASK_EDGE_DEF,
  localparam int unsigned DIM_W    = $clog2(MASK_EDGE)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bnd_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bnd_pkg::CFG_DW-1:0]  pwdata,
  output logic      [bnd_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [bnd_pkg::TW_W-1:0]    tile_width,
  output logic      [DIM_W-1:0]            oc_mod,
  output logic      [DIM_W-1:0]            or_mod
);

  // Reciprocal for the remainder of a 16-bit value by MASK_EDGE.
  localparam int unsigned RECIP = ((32'd1 << 24) + MASK_EDGE - 1) / MASK_EDGE;
  // Bias that makes the signed origin non-negative, folded back afterward.
  localparam int unsigned OFFS  = 32768 % MASK_EDGE;

  logic [bnd_pkg::TW_W-1:0]         tile_width_r;
  logic signed [bnd_pkg::ORG_W-1:0] origin_column_r;
  logic signed [bnd_pkg::ORG_W-1:0] origin_row_r;
  logic [DIM_W-1:0]                 oc_mod_r;
  logic [DIM_W-1:0]                 or_mod_r;
  logic                             wr_en;
  logic [1:0]                       reg_idx;
  logic [DIM_W-1:0]                 wdata_mod;

  // True non-negative modulo of a signed 16-bit value.
  function automatic logic [DIM_W-1:0] wrap_org(input logic [15:0] v);
    logic [15:0] u;
    logic [39:0] prod;
    logic [15:0] q;
    logic [24:0] qd;
    logic [15:0] r;
    logic [15:0] w;
    u    = {~v[15], v[14:0]};
    prod = 40'(u) * 40'(RECIP);
    q    = prod[39:24];
    qd   = 25'(q) * 25'(MASK_EDGE);
    r    = u - qd[15:0];
    if (r >= 16'(OFFS)) begin
      w = r - 16'(OFFS);
    end else begin
      w = r + 16'(MASK_EDGE) - 16'(OFFS);
    end
    return w[DIM_W-1:0];
  endfunction

  assign wr_en     = psel && penable && pwrite;
  assign reg_idx   = paddr[bnd_pkg::CFG_AW-1:2];
  assign wdata_mod = wrap_org(pwdata[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r    <= bnd_pkg::TW_W'(1);
      origin_column_r <= '0;
      origin_row_r    <= '0;
      oc_mod_r        <= '0;
      or_mod_r        <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        bnd_pkg::REG_TILE_WIDTH: begin
          tile_width_r <= pwdata[bnd_pkg::TW_W-1:0];
        end
        bnd_pkg::REG_ORIGIN_COLUMN: begin
          origin_column_r <= pwdata[bnd_pkg::ORG_W-1:0];
          oc_mod_r        <= wdata_mod;
        end
        bnd_pkg::REG_ORIGIN_ROW: begin
          origin_row_r <= pwdata[bnd_pkg::ORG_W-1:0];
          or_mod_r     <= wdata_mod;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bnd_pkg::REG_TILE_WIDTH:    prdata = bnd_pkg::CFG_DW'(tile_width_r);
      bnd_pkg::REG_ORIGIN_COLUMN: prdata = {{16{origin_column_r[15]}}, origin_column_r};
      bnd_pkg::REG_ORIGIN_ROW:    prdata = {{16{origin_row_r[15]}}, origin_row_r};
      default:                    prdata = '0;
    endcase
  end

  assign pready     = 1'b1;
  assign tile_width = tile_width_r;
  assign oc_mod     = oc_mod_r;
  assign or_mod     = or_mod_r;

endmodule

`default_nettype wire

>>> design/bnd_addr.sv
// ----------------------------------------------------------------------------
// bnd_addr
// Tile position counters, mask address generation and the mask memory port.
// ----------------------------------------------------------------------------
`default_nettype none

module bnd_addr #(
  parameter int unsigned MASK_EDGE = bnd_pkg::MASK_EDGE_DEF,
  localparam int unsigned DIM_W    = $clog2(MASK_EDGE),
  localparam int unsigned ADDR_W   = $clog2(MASK_EDGE * MASK_EDGE)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_acc,
  input  wire bnd_pkg::in_item_t        in_item,
  input  wire logic                     advance,
  input  wire logic [bnd_pkg::TW_W-1:0] tile_width,
  input  wire logic [DIM_W-1:0]         oc_mod,
  input  wire logic [DIM_W-1:0]         or_mod,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic      [ADDR_W-1:0]        ram_addr,
  output logic      [7:0]               ram_wdata,
  output logic                          s1_valid,
  output bnd_pkg::pix_t                 s1
);

  localparam int unsigned ENTRIES = MASK_EDGE * MASK_EDGE;
  localparam int unsigned MAXW    = (bnd_pkg::MAX_TILE_WIDTH < 8191) ?
                                    bnd_pkg::MAX_TILE_WIDTH : 8191;
  localparam logic [DIM_W:0]    DIM_V    = (DIM_W + 1)'(MASK_EDGE);
  localparam logic [DIM_W-1:0]  DIM_LAST = DIM_W'(MASK_EDGE - 1);
  localparam logic [ADDR_W-1:0] DIM_A    = ADDR_W'(MASK_EDGE);

  logic [bnd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0]          col_ph_r, col_ph_nxt;
  logic [DIM_W-1:0]          row_r, row_nxt;
  logic                      odd_r, odd_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  bnd_pkg::pix_t             s1_r, s1_nxt;

  logic                      pix_acc;
  logic                      load_acc;
  logic                      load_ok;
  logic [DIM_W:0]            mx_sum, my_sum;
  logic [DIM_W-1:0]          mx, my;
  logic [ADDR_W-1:0]         rd_addr;
  logic [bnd_pkg::TW_W-1:0]  tw_eff;
  logic [bnd_pkg::COL_W:0]   colp1;
  logic                      wrap_row;
  logic [DIM_W:0]            col_ph_p1, row_p1;
  logic [DIM_W-1:0]          col_ph_inc, row_inc;
  logic [15:0]               gray_prod;
  logic [3:0]                base;
  logic [7:0]                rem8;

  assign pix_acc  = in_acc && (in_item.func == bnd_pkg::FUNC_PIXEL);
  assign load_acc = in_acc && (in_item.func == bnd_pkg::FUNC_LOAD);
  assign load_ok  = 32'(in_item.mask_address) < ENTRIES;

  // Mask coordinates: origin phase plus position, each below MASK_EDGE.
  assign mx_sum  = {1'b0, oc_mod} + {1'b0, col_ph_r};
  assign my_sum  = {1'b0, or_mod} + {1'b0, row_r};
  assign mx      = (mx_sum >= DIM_V) ? DIM_W'(mx_sum - DIM_V) : DIM_W'(mx_sum);
  assign my      = (my_sum >= DIM_V) ? DIM_W'(my_sum - DIM_V) : DIM_W'(my_sum);
  assign rd_addr = ADDR_W'(ADDR_W'(my) * DIM_A) + ADDR_W'(mx);

  assign ram_we    = load_acc && load_ok;
  assign ram_re    = pix_acc;
  assign ram_addr  = load_acc ? ADDR_W'(in_item.mask_address) : rd_addr;
  assign ram_wdata = in_item.mask_threshold;

  always_comb begin
    if (tile_width == '0) begin
      tw_eff = bnd_pkg::TW_W'(1);
    end else if (32'(tile_width) > MAXW) begin
      tw_eff = bnd_pkg::TW_W'(MAXW);
    end else begin
      tw_eff = tile_width;
    end
  end

  assign colp1      = {1'b0, col_r} + (bnd_pkg::COL_W + 1)'(1);
  assign wrap_row   = colp1 >= tw_eff;
  assign col_ph_p1  = {1'b0, col_ph_r} + (DIM_W + 1)'(1);
  assign row_p1     = {1'b0, row_r} + (DIM_W + 1)'(1);
  assign col_ph_inc = (col_ph_p1 == DIM_V) ? '0 : DIM_W'(col_ph_p1);
  assign row_inc    = (row_p1 == DIM_V) ? '0 : DIM_W'(row_p1);

  // Split gray into base level and remainder of the step.
  assign gray_prod = 16'(in_item.pixel_gray) * 16'(bnd_pkg::GRAY_RECIP);
  assign base      = gray_prod[15:bnd_pkg::GRAY_RECIP_SHIFT];
  assign rem8      = in_item.pixel_gray - 8'(8'(base) * 8'(bnd_pkg::GRAY_STEP));

  always_comb begin
    col_nxt    = col_r;
    col_ph_nxt = col_ph_r;
    row_nxt    = row_r;
    odd_nxt    = odd_r;
    if (pix_acc) begin
      if (in_item.tile_last) begin
        col_nxt    = '0;
        col_ph_nxt = '0;
        row_nxt    = '0;
        odd_nxt    = 1'b0;
      end else begin
        odd_nxt = !odd_r;
        if (wrap_row) begin
          col_nxt    = '0;
          col_ph_nxt = '0;
          row_nxt    = row_inc;
        end else begin
          col_nxt    = colp1[bnd_pkg::COL_W-1:0];
          col_ph_nxt = colp1[bnd_pkg::COL_W] ? '0 : col_ph_inc;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (advance) begin
      s1_valid_nxt = pix_acc;
    end
    if (pix_acc) begin
      s1_nxt.odd  = odd_r;
      s1_nxt.last = in_item.tile_last;
      s1_nxt.base = base;
      s1_nxt.rem  = rem8[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      col_ph_r   <= '0;
      row_r      <= '0;
      odd_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      col_ph_r   <= col_ph_nxt;
      row_r      <= row_nxt;
      odd_r      <= odd_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  a_port_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("mask write and read in the same cycle");

  a_tile_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pix_acc && in_item.tile_last |=> (col_r == '0) && (row_r == '0) && !odd_r)
    else $error("position not cleared after last pixel");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_ph_r <= DIM_LAST) && (row_r <= DIM_LAST))
    else $error("mask phase out of range");

endmodule

`default_nettype wire

>>> design/bnd_pack.sv
// ----------------------------------------------------------------------------
// bnd_pack
// Threshold compare on the mask read data, nibble packing and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bnd_pack (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s1_valid,
  input  wire bnd_pkg::pix_t      s1,
  input  wire logic [7:0]         thr,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output bnd_pkg::out_item_t      out_item,
  output logic                    advance
);

  logic                out_valid_r, out_valid_nxt;
  bnd_pkg::out_item_t  out_item_r, out_item_nxt;
  logic [3:0]          held_r, held_nxt;
  logic                fire;
  logic [12:0]         thr_sc;
  logic [12:0]         rem_sc;
  logic [3:0]          level;

  assign advance = !(out_valid_r && out_stall);
  assign fire    = s1_valid && advance;

  // Level steps up when threshold*17 < remainder*256.
  assign thr_sc = 13'(thr) * 13'(bnd_pkg::GRAY_STEP);
  assign rem_sc = {s1.rem, 8'b0};
  assign level  = s1.base + 4'(thr_sc < rem_sc);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    held_nxt      = held_r;
    if (advance) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      if (s1.odd) begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.packed_byte = {held_r, level};
        out_item_nxt.byte_last = s1.last;
        held_nxt               = '0;
      end else if (s1.last) begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.packed_byte = {level, 4'b0};
        out_item_nxt.byte_last = 1'b1;
      end else begin
        held_nxt = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_odd_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1.odd |=> out_valid_r)
    else $error("odd pixel produced no byte");

  a_even_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1.odd && !s1.last |=> !out_valid_r)
    else $error("even pixel produced a byte");

endmodule

`default_nettype wire

>>> design/blue_noise_dither_gray4_packer.sv
// ----------------------------------------------------------------------------
// blue_noise_dither_gray4_packer
// Pipeline: a pixel's mask read data and pixel state are registered first, then
//   the completed byte is registered and presented on out_valid (compare and pack).
// Throughput: one item per cycle while in_stall is low; the mask memory has one
//   port, used by the load write or the pixel read of each item in its transfer cycle.
// Reset: rst_n (synchronous, active low) clears the position counters, the
//   pipeline valids and the registers; mask contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module blue_noise_dither_gray4_packer #(
  parameter int unsigned MASK_EDGE = bnd_pkg::MASK_EDGE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pixel / mask-load channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire bnd_pkg::in_item_t           in_item,
  // packed byte channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bnd_pkg::out_item_t               out_item,
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [bnd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [bnd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [bnd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  localparam int unsigned DIM_W  = $clog2(MASK_EDGE);
  localparam int unsigned ADDR_W = $clog2(MASK_EDGE * MASK_EDGE);

  logic                     advance;
  logic                     in_acc;
  logic [bnd_pkg::TW_W-1:0] tile_width;
  logic [DIM_W-1:0]         oc_mod;
  logic [DIM_W-1:0]         or_mod;
  logic                     ram_we;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_addr;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;
  logic                     s1_valid;
  bnd_pkg::pix_t            s1;

  // Hold the input only while a finished byte waits on a stalled output;
  // the pipeline and the mask read advance together otherwise.
  assign in_stall = !advance;
  assign in_acc   = in_valid && !in_stall;

  // Register file; origins are folded onto the mask phase when written.
  bnd_cfg #(
    .MASK_EDGE (MASK_EDGE)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .tile_width (tile_width),
    .oc_mod     (oc_mod),
    .or_mod     (or_mod)
  );

  // Stage 0: advance the tile position, issue the mask write or read.
  bnd_addr #(
    .MASK_EDGE (MASK_EDGE)
  ) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_item    (in_item),
    .advance    (advance),
    .tile_width (tile_width),
    .oc_mod     (oc_mod),
    .or_mod     (or_mod),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  // Threshold mask: loads and pixel reads never share a cycle, so a read
  // always sees every earlier load without forwarding.
  bnd_ram #(
    .WIDTH (8),
    .DEPTH (MASK_EDGE * MASK_EDGE)
  ) u_mask (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Stage 1: compare against the read threshold, pack two levels per byte.
  bnd_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .thr       (ram_rdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .advance   (advance)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gray8-to-gray4 threshold dither packer. A queue
// of mask loads and pixel tiles feeds a valid/stall driver, and a monitor
// compares every packed byte with the value that an in-bench dither model
// worked out when the item was queued. Register setups change between runs
// of tiles, always with the block drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned MDIM         = bnd_pkg::MASK_EDGE_DEF;
  localparam int unsigned MASK_SIZE    = MDIM * MDIM;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;   // past the register list
  localparam int unsigned NUM_SETUPS   = 12;
  localparam int unsigned ITEM_BUDGET  = 1750;   // pixels plus loads over the run
  localparam int unsigned LOAD_PCT     = 12;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  // One queued item together with the byte it completes, if any.
  typedef struct {
    bnd_pkg::in_item_t  item;
    bit                 makes_byte;
    bnd_pkg::out_item_t byte_want;
  } job_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  bnd_pkg::in_item_t  in_item  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bnd_pkg::out_item_t out_item;

  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [bnd_pkg::CFG_AW-1:0] cfg_paddr   = '0;
  logic [bnd_pkg::CFG_DW-1:0] cfg_pwdata  = '0;
  logic [bnd_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  // Dither model state: mask contents, position counters, register copies.
  logic [7:0]                thr_mem   [MASK_SIZE];
  bit                        thr_known [MASK_SIZE];
  logic [bnd_pkg::COL_W-1:0] col_cnt  = '0;
  logic [7:0]                row_ph   = '0;
  logic [3:0]                held_lvl = '0;
  bit                        odd_pos  = 1'b0;
  logic [bnd_pkg::TW_W-1:0]  width_reg = 13'd1;
  logic signed [15:0]        ocol_reg  = '0;
  logic signed [15:0]        orow_reg  = '0;

  job_t               pending[$];         // items waiting for the driver
  bnd_pkg::out_item_t expected_bytes[$];  // bytes owed by transferred items
  job_t               cur;                // item now on the input channel

  int unsigned hold_off   = 0;
  int unsigned in_calm    = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm   = 0;

  int unsigned px_sent     = 0;
  int unsigned n_loads     = 0;
  int unsigned n_transfers = 0;
  int unsigned n_checked   = 0;
  int unsigned n_setups    = 0;
  int unsigned mismatches  = 0;

  blue_noise_dither_gray4_packer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Dither model
  // --------------------------------------------------------------------------

  // True non-negative modulo onto the mask edge.
  function automatic int unsigned wrap_dim(int v);
    int r;
    r = v % int'(MDIM);
    if (r < 0) r += int'(MDIM);
    return r;
  endfunction

  // Mask entry that the next pixel will read.
  function automatic int unsigned mask_slot();
    int unsigned mx, my;
    mx = wrap_dim(int'(ocol_reg) + int'(col_cnt));
    my = (wrap_dim(int'(orow_reg)) + row_ph) % MDIM;
    return my * MDIM + mx;
  endfunction

  function automatic logic [3:0] dither_level(logic [7:0] gray, logic [7:0] thr);
    int unsigned base, rem;
    base = gray / bnd_pkg::GRAY_STEP;
    rem  = gray - base * bnd_pkg::GRAY_STEP;
    // round up when the threshold sits below the remainder, on a 0..255 scale
    if (32'(thr) * bnd_pkg::GRAY_STEP < rem * 256) base++;
    return base[3:0];
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > bnd_pkg::MAX_TILE_WIDTH) return bnd_pkg::MAX_TILE_WIDTH;
    return 32'(width_reg);
  endfunction

  // Queue a mask load; the unused fields carry noise.
  task automatic queue_load(logic [11:0] addr, logic [7:0] thr);
    job_t j;
    j.item.func           = bnd_pkg::FUNC_LOAD;
    j.item.mask_address   = addr;
    j.item.mask_threshold = thr;
    j.item.pixel_gray     = 8'($urandom);
    j.item.tile_last      = 1'($urandom);
    j.makes_byte          = 1'b0;
    j.byte_want           = '0;
    if (32'(addr) < MASK_SIZE) begin
      thr_mem[addr]   = thr;
      thr_known[addr] = 1'b1;
    end
    pending.push_back(j);
    n_loads++;
  endtask

  // Queue a pixel, loading its mask entry first if it was never written.
  task automatic queue_pixel(logic [7:0] gray, bit last);
    job_t        j;
    int unsigned slot;
    logic [3:0]  lvl;
    slot = mask_slot();
    if (!thr_known[slot]) queue_load(12'(slot), 8'($urandom));
    lvl = dither_level(gray, thr_mem[slot]);
    j.item.func           = bnd_pkg::FUNC_PIXEL;
    j.item.pixel_gray     = gray;
    j.item.tile_last      = last;
    j.item.mask_address   = 12'($urandom);
    j.item.mask_threshold = 8'($urandom);
    j.makes_byte          = 1'b0;
    j.byte_want           = '0;
    if (odd_pos) begin
      j.makes_byte            = 1'b1;
      j.byte_want.packed_byte = {held_lvl, lvl};
      j.byte_want.byte_last   = last;
      odd_pos  = 1'b0;
      held_lvl = '0;
    end else if (last) begin
      // lone final pixel: level high, zero low nibble
      j.makes_byte            = 1'b1;
      j.byte_want.packed_byte = {lvl, 4'h0};
      j.byte_want.byte_last   = 1'b1;
    end else begin
      held_lvl = lvl;
      odd_pos  = 1'b1;
    end
    if (last) begin
      col_cnt  = '0;
      row_ph   = '0;
      held_lvl = '0;
      odd_pos  = 1'b0;
    end else if (32'(col_cnt) + 1 >= eff_width()) begin
      col_cnt = '0;
      row_ph  = 8'((row_ph + 1) % MDIM);
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    pending.push_back(j);
    px_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] pick_gray();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6)  return 8'd0;
    if (r < 12) return 8'd255;
    if (r < 20) return 8'(bnd_pkg::GRAY_STEP * $urandom_range(0, 15));      // zero remainder
    if (r < 28) return 8'(bnd_pkg::GRAY_STEP * $urandom_range(0, 14) + 16); // largest remainder
    return 8'($urandom);
  endfunction

  function automatic int unsigned pick_tile_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 20) return 2;
    if (r < 75) return $urandom_range(3, 24);
    if (r < 95) return $urandom_range(25, 90);
    return $urandom_range(91, 300);
  endfunction

  // Gap or stall length: mostly none or short, a few long, and now and then a
  // calm stretch with no gaps at all.
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 15) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 560) return 0;
    if (r < 860) return $urandom_range(1, 3);
    if (r < 975) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Queue whole tiles with loads sprinkled in until the item count reaches
  // goal; the tile cut off there stays open into the next register setup.
  task automatic run_tiles(int unsigned goal);
    int unsigned len, k;
    while (px_sent + n_loads < goal) begin
      len = pick_tile_len();
      for (k = 0; k < len && px_sent + n_loads < goal; k++) begin
        if ($urandom_range(0, 99) < LOAD_PCT) queue_load(12'($urandom), 8'($urandom));
        queue_pixel(pick_gray(), k == len - 1);
      end
    end
  endtask

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, what, want, got);
  endtask

  // One APB access: setup cycle, access cycle, done at the edge with pready.
  task automatic cfg_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write a register, mirror it in the model, and read it back unless it is the unused index.
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    cfg_access(1'b1, idx, val, rd);
    case (idx)
      bnd_pkg::REG_TILE_WIDTH:    width_reg = val[bnd_pkg::TW_W-1:0];
      bnd_pkg::REG_ORIGIN_COLUMN: ocol_reg  = val[bnd_pkg::ORG_W-1:0];
      bnd_pkg::REG_ORIGIN_ROW:    orow_reg  = val[bnd_pkg::ORG_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      cfg_access(1'b0, idx, '0, rd);
      case (idx)
        bnd_pkg::REG_TILE_WIDTH: begin
          if (rd[bnd_pkg::TW_W-1:0] !== width_reg)
            flag("tile_width readback", 32'(width_reg), rd);
        end
        bnd_pkg::REG_ORIGIN_COLUMN: begin
          if (rd[bnd_pkg::ORG_W-1:0] !== ocol_reg)
            flag("origin_column readback", 32'(ocol_reg), rd);
        end
        default: begin
          if (rd[bnd_pkg::ORG_W-1:0] !== orow_reg)
            flag("origin_row readback", 32'(orow_reg), rd);
        end
      endcase
    end
  endtask

  // Hold until every queued item is transferred and every byte has come back,
  // then let the pipeline finish trailing loads.
  task automatic settle();
    @(negedge clk);
    while (pending.size() != 0 || in_valid || expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued items, hold each until its transfer, then advance
  // after a random gap. Expected bytes are filed at the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic in_go;
    in_go = in_valid && (in_stall === 1'b0);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_go) begin
        if (cur.makes_byte) expected_bytes.push_back(cur.byte_want);
        n_transfers++;
        hold_off = next_gap(in_calm);
      end
      if (!in_valid || in_go) begin
        if (hold_off != 0) begin
          hold_off--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur = pending.pop_front();
          in_item  <= cur.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each byte transfer against the oldest expectation, then
  // pick the stall for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bnd_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          flag("unexpected byte", '0, 32'(out_item));
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.packed_byte !== want.packed_byte)
            flag("packed_byte", 32'(want.packed_byte), 32'(out_item.packed_byte));
          if (out_item.byte_last !== want.byte_last)
            flag("byte_last", 32'(want.byte_last), 32'(out_item.byte_last));
          n_checked++;
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = next_gap(out_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed items at reset register values, then a series
  // of register setups each followed by random tiles.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned s, k, queued, goal;
    logic [31:0] w, oc, orow;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Width 1 at reset: every pixel steps one mask row, column stays 0.
    queue_load(12'd0,   8'd0);
    queue_load(12'd64,  8'd255);
    queue_load(12'd128, 8'd240);   // just under the round-up edge for remainder 16
    queue_load(12'd192, 8'd241);   // just over it
    queue_load(12'hFFF, 8'hFF);    // top address
    queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd16,  1'b0);
    queue_load(12'd7, 8'h5A);      // load between the two pixels of a pair
    queue_pixel(8'd16,  1'b1);     // closes the pair and the tile
    queue_pixel(8'd254, 1'b1);     // single-pixel tile: low nibble zero
    queue_pixel(8'd17,  1'b0);
    queue_pixel(8'h80,  1'b0);
    queue_pixel(8'h55,  1'b0);
    queue_pixel(8'hAA,  1'b1);
    // one tile longer than the mask so the row phase wraps
    for (k = 0; k < MDIM + 2; k++) queue_pixel(pick_gray(), k == MDIM + 1);
    settle();

    for (s = 0; s < NUM_SETUPS; s++) begin
      oc   = $urandom;
      orow = $urandom;
      case (s)
        0:  begin w = 3;             oc = 32'hFFFF_8000; orow = 32'h0000_7FFF; end
        1:  begin w = 0;             oc = 32'hFFFF_FFFF; orow = 32'h1234_FFC0; end
        2:  begin w = 8191;          oc = 32'h0000_7FFF; orow = 32'h0000_8000; end
        3:  w = bnd_pkg::MAX_TILE_WIDTH;
        4:  begin w = 1;             oc = 32'hFFFF_FFFB; orow = 32'd63;        end
        5:  w = 2;
        6:  begin w = 64;            oc = 32'hFFFF_FFDB; orow = 32'd100;       end
        7:  w = 63;
        8:  w = 65;
        10: w = 32'hFFFF_E005;       // junk above the 13-bit field
        default: w = $urandom_range(1, 40);
      endcase
      set_reg(bnd_pkg::REG_TILE_WIDTH, w);
      set_reg(bnd_pkg::REG_ORIGIN_COLUMN, oc);
      set_reg(bnd_pkg::REG_ORIGIN_ROW, orow);
      if (s % 4 == 1) set_reg(REG_UNUSED, $urandom);
      n_setups++;
      @(negedge clk);
      // share what is left of the item budget among the remaining setups
      queued = px_sent + n_loads;
      goal   = (queued < ITEM_BUDGET) ?
               queued + (ITEM_BUDGET - queued) / (NUM_SETUPS - s) : queued;
      run_tiles(goal);
      settle();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d pixels and %0d mask loads in %0d transfers; checked %0d packed bytes.",
             px_sent, n_loads, n_transfers, n_checked);
    $display("Used %0d register setups: widths 0 to 8191, origins at both 16-bit extremes.",
             n_setups);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #40_000_000;
    $display("timeout: %0d items pending, %0d bytes owed", pending.size(),
             expected_bytes.size());
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
